// ===== hw/rtl/irc_pkg.sv =====
// irc_pkg: shared types and constants for the IPv4 rule classifier.
// No dependencies.
package irc_pkg;

  localparam int unsigned Rules       = 16;
  localparam int unsigned AddrEntries = 4;
  localparam int unsigned PortEntries = 4;
  localparam int unsigned ProtoEntries = 4;
  localparam int unsigned RuleW       = $clog2(Rules);

  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;

  typedef enum logic {
    ACT_WRITE    = 1'b0,
    ACT_CLASSIFY = 1'b1
  } action_e;

  // word_select codes
  localparam logic [4:0] SelCtrl     = 5'd0;
  localparam logic [4:0] SelTos      = 5'd1;
  localparam logic [4:0] SelSrcAddr  = 5'd2;
  localparam logic [4:0] SelSrcMask  = 5'd6;
  localparam logic [4:0] SelDstAddr  = 5'd10;
  localparam logic [4:0] SelDstMask  = 5'd14;
  localparam logic [4:0] SelSrcPort  = 5'd18;
  localparam logic [4:0] SelDstPort  = 5'd22;
  localparam logic [4:0] SelProto    = 5'd26;
  localparam logic [4:0] SelEnd      = 5'd30;

  typedef struct packed {
    logic        action;
    logic [3:0]  rule_index;
    logic [4:0]  word_select;
    logic [31:0] write_value;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [7:0]  tos;
    logic [7:0]  protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } in_word_t;

  typedef struct packed {
    logic       matched;
    logic [3:0] matched_rule;
  } out_word_t;

  // Word travelling along the cell chain.
  typedef struct packed {
    logic       valid;
    logic       classify;
    logic [3:0] rule_index;
    logic [4:0] word_select;
    logic [31:0] write_value;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [7:0]  tos;
    logic [7:0]  protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic        hit;
    logic [3:0]  hit_rule;
  } chain_t;

  function automatic logic [2:0] clamp_cnt(logic [2:0] n, int unsigned lim);
    logic [2:0] l;
    l = 3'(lim);
    return (n > l) ? l : n;
  endfunction

endpackage

// ===== hw/rtl/irc_cell.sv =====
// irc_cell: one rule slot; holds the rule and checks the passing word.
// Depends on irc_pkg.
module irc_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [3:0]            cell_idx_i,
  input  irc_pkg::chain_t       prev_i,
  output irc_pkg::chain_t       next_o
);
  import irc_pkg::*;

  logic [18:0] ctrl_q;
  logic [23:0] tos_q;
  logic [31:0] saddr_q [AddrEntries];
  logic [31:0] smask_q [AddrEntries];
  logic [31:0] daddr_q [AddrEntries];
  logic [31:0] dmask_q [AddrEntries];
  logic [31:0] sport_q [PortEntries];
  logic [31:0] dport_q [PortEntries];
  logic [7:0]  proto_q [ProtoEntries];
  chain_t      out_q;
  chain_t      out_d;

  logic        wr;
  logic [4:0]  sel;
  logic [1:0]  k;
  logic [2:0]  ns, nd, np, nsp, ndp;
  logic        s_ok, d_ok, t_ok, p_ok, sp_ok, dp_ok, tcpudp, hit;
  logic [7:0]  tv;

  assign wr  = prev_i.valid && !prev_i.classify && (prev_i.rule_index == cell_idx_i);
  assign sel = prev_i.word_select;
  assign k   = sel[1:0] - 2'd2;  // (sel-2)&3 ; same mod-4 for 18 and 26

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (wr && sel == SelCtrl) begin
      ctrl_q <= prev_i.write_value[18:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      if (sel == SelTos) tos_q <= prev_i.write_value[23:0];
      for (int i = 0; i < AddrEntries; i++) begin
        if (32'(k) == 32'(i)) begin
          if (sel >= SelSrcAddr && sel < SelSrcMask) saddr_q[i] <= prev_i.write_value;
          if (sel >= SelSrcMask && sel < SelDstAddr) smask_q[i] <= prev_i.write_value;
          if (sel >= SelDstAddr && sel < SelDstMask) daddr_q[i] <= prev_i.write_value;
          if (sel >= SelDstMask && sel < SelSrcPort) dmask_q[i] <= prev_i.write_value;
        end
      end
      for (int i = 0; i < PortEntries; i++) begin
        if (32'(k) == 32'(i)) begin
          if (sel >= SelSrcPort && sel < SelDstPort) sport_q[i] <= prev_i.write_value;
          if (sel >= SelDstPort && sel < SelProto)   dport_q[i] <= prev_i.write_value;
        end
      end
      for (int i = 0; i < ProtoEntries; i++) begin
        if (32'(k) == 32'(i) && sel >= SelProto && sel < SelEnd)
          proto_q[i] <= prev_i.write_value[7:0];
      end
    end
  end

  always_comb begin
    ns  = clamp_cnt(ctrl_q[6:4], AddrEntries);
    nd  = clamp_cnt(ctrl_q[9:7], AddrEntries);
    np  = clamp_cnt(ctrl_q[12:10], ProtoEntries);
    nsp = clamp_cnt(ctrl_q[15:13], PortEntries);
    ndp = clamp_cnt(ctrl_q[18:16], PortEntries);
    s_ok = (ns == 3'd0);
    d_ok = (nd == 3'd0);
    for (int i = 0; i < AddrEntries; i++) begin
      if (3'(i) < ns && ((prev_i.src_ip & smask_q[i]) == (saddr_q[i] & smask_q[i])))
        s_ok = 1'b1;
      if (3'(i) < nd && ((prev_i.dst_ip & dmask_q[i]) == (daddr_q[i] & dmask_q[i])))
        d_ok = 1'b1;
    end
    tv   = prev_i.tos & tos_q[7:0];
    t_ok = !ctrl_q[3] || (tv >= tos_q[15:8] && tv <= tos_q[23:16]);
    p_ok = (np == 3'd0);
    for (int i = 0; i < ProtoEntries; i++)
      if (3'(i) < np && proto_q[i] == prev_i.protocol) p_ok = 1'b1;
    sp_ok = (nsp == 3'd0);
    dp_ok = (ndp == 3'd0);
    for (int i = 0; i < PortEntries; i++) begin
      if (3'(i) < nsp && prev_i.src_port >= sport_q[i][15:0]
          && prev_i.src_port <= sport_q[i][31:16]) sp_ok = 1'b1;
      if (3'(i) < ndp && prev_i.dst_port >= dport_q[i][15:0]
          && prev_i.dst_port <= dport_q[i][31:16]) dp_ok = 1'b1;
    end
    tcpudp = (prev_i.protocol == ProtoTcp) || (prev_i.protocol == ProtoUdp);
    hit = prev_i.classify && ctrl_q[0] && !ctrl_q[1] && !ctrl_q[2] && s_ok && d_ok
          && t_ok && p_ok && (!tcpudp || (sp_ok && dp_ok));
  end

  // Cells run in ascending slot order, so a later hit overrides: highest wins.
  always_comb begin
    out_d          = prev_i;
    out_d.hit      = prev_i.hit | hit;
    out_d.hit_rule = hit ? cell_idx_i : prev_i.hit_rule;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else begin
      out_q <= out_d;
    end
  end

  assign next_o = out_q;
endmodule

// ===== hw/rtl/ipv4_rule_classifier_unit.sv =====
// ipv4_rule_classifier_unit: top level, a chain of irc_cell rule slots.
// Depends on irc_pkg and irc_cell.
//
// Usage:
//  - Command channel: in_i is taken at a clock edge with start high and
//    busy low. action 0 writes one rule word, action 1 classifies a header.
//  - Result channel: done_o pulses for one cycle with out_o; the receiver
//    cannot stall, so every result is taken when shown.
//  - Structure: Rules cells in a row, slot 0 first. Each cell stores one
//    rule, checks the word passing by, and hands it on every cycle. A hit in
//    a later (higher) slot replaces an earlier one, so the highest wins.
//  - Path: a word passes from accept to done_o through each cell's output register in turn.
//  - Throughput: one word per cycle; busy is never asserted since
//    writes land in their cell as the word passes and a later word only sees
//    the cell after it, keeping the order in which words were accepted.
//  - Reset: clears every rule's control word (all unused) and the chain's
//    registers; list contents are undefined until written.
//  - Writes yield matched 0 and rule 0.
module ipv4_rule_classifier_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  irc_pkg::in_word_t    in_i,
  output logic                 done_o,
  output irc_pkg::out_word_t   out_o
);
  import irc_pkg::*;

  chain_t link [Rules+1];

  assign busy = 1'b0;

  always_comb begin
    link[0]             = '0;
    link[0].valid       = start;
    link[0].classify    = (in_i.action == ACT_CLASSIFY);
    link[0].rule_index  = in_i.rule_index;
    link[0].word_select = in_i.word_select;
    link[0].write_value = in_i.write_value;
    link[0].src_ip      = in_i.src_ip;
    link[0].dst_ip      = in_i.dst_ip;
    link[0].tos         = in_i.tos;
    link[0].protocol    = in_i.protocol;
    link[0].src_port    = in_i.src_port;
    link[0].dst_port    = in_i.dst_port;
  end

  for (genvar g = 0; g < Rules; g++) begin : g_cell
    irc_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cell_idx_i(4'(g)),
      .prev_i    (link[g]),
      .next_o    (link[g+1])
    );
  end

  assign done_o              = link[Rules].valid;
  assign out_o.matched       = link[Rules].hit;
  assign out_o.matched_rule  = link[Rules].hit ? link[Rules].hit_rule : 4'd0;
endmodule

// ===== hw/rtl/irc_checker.sv =====
// irc_checker: port-level assertions for ipv4_rule_classifier_unit.
// Depends on irc_pkg; bound to the top level below.
module irc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input irc_pkg::in_word_t  in_i,
  input logic               done_o,
  input irc_pkg::out_word_t out_o
);
  import irc_pkg::*;

  a_no_rule_without_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !out_o.matched |-> out_o.matched_rule == 4'd0) else $error("rule without match");

  a_write_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && in_i.action == ACT_WRITE |-> ##16 (done_o && !out_o.matched))
    else $error("write gave match");

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##16 done_o) else $error("missing result");

  a_idle_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##16 (!done_o || !rst_ni)) else $error("extra result");
endmodule

bind ipv4_rule_classifier_unit irc_checker u_irc_checker (.*);

// ===== tb/testbench.sv =====
// testbench: self-checking bench for ipv4_rule_classifier_unit.
// Depends on irc_pkg and the RTL of the unit. Loads rules word by word, classifies
// headers, and checks every result word against a predictor held in a scoreboard class.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import irc_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned NumRandom = 1000;

  // List kinds tracked for "written" flags; an entry is read only once written.
  localparam int LSrcA = 0, LSrcM = 1, LDstA = 2, LDstM = 3, LSPort = 4, LDPort = 5,
                 LProto = 6;

  // Classifier scoreboard: rule table copy, expected result queue, mismatch count.
  class classify_scoreboard;
    logic [18:0] ctrl_q [Rules];
    logic [23:0] tos_q [Rules];
    logic [31:0] src_addr [Rules][4];
    logic [31:0] src_mask [Rules][4];
    logic [31:0] dst_addr [Rules][4];
    logic [31:0] dst_mask [Rules][4];
    logic [31:0] sport_rng [Rules][4];
    logic [31:0] dport_rng [Rules][4];
    logic [7:0]  proto_lst [Rules][4];
    bit          tos_wr [Rules];
    bit          list_wr [Rules][7][4];
    out_word_t   pending [$];
    int          errors;

    function new();
      foreach (ctrl_q[r]) begin
        ctrl_q[r] = '0;
        tos_wr[r] = 0;
        foreach (list_wr[r][l]) foreach (list_wr[r][l][k]) list_wr[r][l][k] = 0;
      end
      errors = 0;
    endfunction

    // Number of leading entries of a list that have been written.
    function int avail(int r, int l);
      int n;
      n = 0;
      while (n < 4 && list_wr[r][l][n]) n++;
      return n;
    endfunction

    // Shrinks the count fields of a control word, and clears its ToS enable, so no unwritten entry is read.
    function logic [18:0] legal_ctrl(int r, logic [18:0] raw);
      logic [18:0] c;
      int lsb [5];
      int a [5];
      int v;
      c = raw;
      lsb = '{4, 7, 10, 13, 16};
      a[0] = (avail(r, LSrcA) < avail(r, LSrcM)) ? avail(r, LSrcA) : avail(r, LSrcM);
      a[1] = (avail(r, LDstA) < avail(r, LDstM)) ? avail(r, LDstA) : avail(r, LDstM);
      a[2] = avail(r, LProto);
      a[3] = avail(r, LSPort);
      a[4] = avail(r, LDPort);
      for (int i = 0; i < 5; i++) begin
        v = int'(c[lsb[i] +: 3]);
        if (!(v >= 4 && a[i] == 4)) v = v % (a[i] + 1);
        c[lsb[i] +: 3] = 3'(v);
      end
      if (!tos_wr[r]) c[3] = 1'b0;
      return c;
    endfunction

    function int clamp4(logic [2:0] n);
      return (n > 3'd4) ? 4 : int'(n);
    endfunction

    function bit rule_hit(int r, in_word_t w);
      logic [18:0] c;
      logic [7:0] tv;
      bit ok;
      int n;
      c = ctrl_q[r];
      if (!c[0] || c[1] || c[2]) return 0;
      n = clamp4(c[6:4]);
      ok = (n == 0);
      for (int i = 0; i < n; i++)
        if ((w.src_ip & src_mask[r][i]) == (src_addr[r][i] & src_mask[r][i])) ok = 1;
      if (!ok) return 0;
      n = clamp4(c[9:7]);
      ok = (n == 0);
      for (int i = 0; i < n; i++)
        if ((w.dst_ip & dst_mask[r][i]) == (dst_addr[r][i] & dst_mask[r][i])) ok = 1;
      if (!ok) return 0;
      if (c[3]) begin
        tv = w.tos & tos_q[r][7:0];
        if (tv < tos_q[r][15:8] || tv > tos_q[r][23:16]) return 0;
      end
      n = clamp4(c[12:10]);
      ok = (n == 0);
      for (int i = 0; i < n; i++) if (proto_lst[r][i] == w.protocol) ok = 1;
      if (!ok) return 0;
      if (w.protocol != ProtoTcp && w.protocol != ProtoUdp) return 1;
      n = clamp4(c[15:13]);
      ok = (n == 0);
      for (int i = 0; i < n; i++)
        if (w.src_port >= sport_rng[r][i][15:0] && w.src_port <= sport_rng[r][i][31:16])
          ok = 1;
      if (!ok) return 0;
      n = clamp4(c[18:16]);
      ok = (n == 0);
      for (int i = 0; i < n; i++)
        if (w.dst_port >= dport_rng[r][i][15:0] && w.dst_port <= dport_rng[r][i][31:16])
          ok = 1;
      return ok;
    endfunction

    function void store_word(int r, logic [4:0] sel, logic [31:0] v);
      int k;
      k = int'(sel - 5'd2) & 3;
      if (sel == SelCtrl) ctrl_q[r] = v[18:0];
      else if (sel == SelTos) begin
        tos_q[r] = v[23:0];
        tos_wr[r] = 1;
      end else if (sel < SelSrcMask) begin
        src_addr[r][k] = v; list_wr[r][LSrcA][k] = 1;
      end else if (sel < SelDstAddr) begin
        src_mask[r][k] = v; list_wr[r][LSrcM][k] = 1;
      end else if (sel < SelDstMask) begin
        dst_addr[r][k] = v; list_wr[r][LDstA][k] = 1;
      end else if (sel < SelSrcPort) begin
        dst_mask[r][k] = v; list_wr[r][LDstM][k] = 1;
      end else if (sel < SelDstPort) begin
        sport_rng[r][k] = v; list_wr[r][LSPort][k] = 1;
      end else if (sel < SelProto) begin
        dport_rng[r][k] = v; list_wr[r][LDPort][k] = 1;
      end else if (sel < SelEnd) begin
        proto_lst[r][k] = v[7:0]; list_wr[r][LProto][k] = 1;
      end
    endfunction

    // Accepted command word: update table or predict the classification.
    function void note(in_word_t w);
      out_word_t e;
      e = '0;
      if (w.action == ACT_WRITE) store_word(int'(w.rule_index), w.word_select, w.write_value);
      else begin
        for (int r = Rules - 1; r >= 0; r--)
          if (rule_hit(r, w)) begin
            e.matched = 1'b1;
            e.matched_rule = 4'(r);
            break;
          end
      end
      pending.push_back(e);
    endfunction

    function void check(out_word_t o);
      out_word_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word matched=%0b rule=%0d",
                                   o.matched, o.matched_rule);
        return;
      end
      e = pending.pop_front();
      if (o.matched !== e.matched || o.matched_rule !== e.matched_rule) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected matched=%0b rule=%0d, got matched=%0b rule=%0d",
                   e.matched, e.matched_rule, o.matched, o.matched_rule);
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_i = '0;
  logic      done_o;
  out_word_t out_o;

  classify_scoreboard sb = new();
  int unsigned cycles = 0;
  logic [31:0] ip_pool [6] = '{32'h0, 32'hFFFF_FFFF, 32'hC0A8_0101, 32'h0A00_0005,
                               32'hAC10_2040, 32'h8080_8080};
  logic [15:0] port_pool [6] = '{16'd0, 16'hFFFF, 16'd80, 16'd443, 16'd1024, 16'd53};
  logic [7:0]  proto_pool [6] = '{ProtoTcp, ProtoUdp, 8'd1, 8'd0, 8'hFF, 8'd47};

  ipv4_rule_classifier_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .in_i  (in_i),
    .done_o(done_o),
    .out_o (out_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && done_o) sb.check(out_o);
  end

  initial begin
    wait (cycles >= CycleLimit);
    $display("FAIL ipv4_rule_classifier_unit");
    $finish;
  end

  // Presents one command word and holds it until taken, then idles a random gap.
  task automatic issue(in_word_t w);
    int gap;
    in_i  <= w;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    sb.note(w);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if ($urandom_range(0, 9) < 4) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic in_word_t rand_word();
    in_word_t w;
    w = $bits(in_word_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    return w;
  endfunction

  task automatic put(int r, logic [4:0] sel, logic [31:0] v);
    in_word_t w;
    w = rand_word();
    w.action = ACT_WRITE;
    w.rule_index = 4'(r);
    w.word_select = sel;
    w.write_value = (sel == SelCtrl) ? 32'(sb.legal_ctrl(r, v[18:0])) | (v & 32'hFFF8_0000)
                                     : v;
    issue(w);
  endtask

  task automatic classify(logic [31:0] sip, logic [31:0] dip, logic [7:0] tos,
                          logic [7:0] proto, logic [15:0] sp, logic [15:0] dp);
    in_word_t w;
    w = rand_word();
    w.action = ACT_CLASSIFY;
    w.src_ip = sip; w.dst_ip = dip; w.tos = tos;
    w.protocol = proto; w.src_port = sp; w.dst_port = dp;
    issue(w);
  endtask

  function automatic logic [31:0] pick_ip();
    logic [31:0] a;
    a = ip_pool[$urandom_range(0, 5)];
    if ($urandom_range(0, 3) == 0) a ^= 32'($urandom_range(0, 255));
    if ($urandom_range(0, 7) == 0) a = $urandom;
    return a;
  endfunction

  function automatic logic [31:0] pick_mask();
    case ($urandom_range(0, 4))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'hFFFF_FF00;
      3: return 32'hFFFF_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_port();
    return ($urandom_range(0, 4) == 0) ? 16'($urandom) : port_pool[$urandom_range(0, 5)];
  endfunction

  function automatic logic [7:0] pick_proto();
    return ($urandom_range(0, 5) == 0) ? 8'($urandom) : proto_pool[$urandom_range(0, 5)];
  endfunction

  task automatic random_classify();
    classify(pick_ip(), pick_ip(), 8'($urandom), pick_proto(), pick_port(), pick_port());
  endtask

  // One rule load: some list words, a control word, then a few headers.
  task automatic load_rule(output int n);
    int r, words;
    logic [4:0] sel;
    logic [31:0] v;
    logic [15:0] lo, hi;
    r = $urandom_range(0, Rules - 1);
    words = $urandom_range(0, 10);
    n = 0;
    for (int i = 0; i < words; i++) begin
      sel = 5'($urandom_range(1, 29));
      if (sel == SelTos) v = {8'($urandom), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 64)), $urandom_range(0, 1) ? 8'hFF :
                              8'($urandom)};
      else if (sel < SelSrcMask || (sel >= SelDstAddr && sel < SelDstMask)) v = pick_ip();
      else if (sel < SelSrcPort) v = pick_mask();
      else if (sel < SelProto) begin
        lo = pick_port(); hi = $urandom_range(0, 3) ? lo + 16'($urandom_range(0, 500))
                                                   : pick_port();
        v = {hi, lo};
      end else v = {24'($urandom), pick_proto()};
      put(r, sel, v);
      n++;
    end
    v = $urandom;
    v[0] = ($urandom_range(0, 7) != 0);
    v[1] = ($urandom_range(0, 7) == 0);
    v[2] = ($urandom_range(0, 7) == 0);
    put(r, SelCtrl, v);
    n++;
    repeat ($urandom_range(1, 4)) begin
      random_classify();
      n++;
    end
  endtask

  initial begin
    int sent, n;
    in_word_t w;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, a fully listed TCP/UDP rule, an all-wildcard rule,
    // downlink and IPv6 flags, oversize counts, ignored selects and other protocols.
    classify(32'h0, 32'hFFFF_FFFF, 8'hFF, ProtoTcp, 16'h0, 16'hFFFF);
    put(15, SelSrcAddr, 32'hFFFF_FFFF);
    put(15, SelSrcMask, 32'hFFFF_FFFF);
    put(15, SelTos, 32'hFF_FF00_FF);
    for (int k = 0; k < 4; k++) put(15, SelProto + 5'(k), (k == 0) ? 32'(ProtoTcp) :
                                                          32'(ProtoUdp));
    put(15, SelSrcPort, 32'hFFFF_0000);
    put(15, SelDstPort, 32'h0050_0050);
    put(15, SelCtrl, 32'h1_3C19); // used, tos, 1 src, 7 protos, 1 sport, 1 dport
    classify(32'hFFFF_FFFF, 32'h0, 8'h00, ProtoTcp, 16'hFFFF, 16'd80);
    classify(32'hFFFF_FFFF, 32'h0, 8'h00, ProtoUdp, 16'h0, 16'd81);
    put(3, SelCtrl, 32'h1);
    classify(32'hFFFF_FFFF, 32'h1, 8'h7F, 8'd1, 16'd80, 16'd80);
    put(15, SelCtrl, 32'h1_3C1B); // downlink
    classify(32'hFFFF_FFFF, 32'h0, 8'h00, ProtoTcp, 16'd1, 16'd80);
    put(15, SelCtrl, 32'h1_3C1D); // IPv6
    classify(32'hFFFF_FFFF, 32'h0, 8'h00, ProtoTcp, 16'd1, 16'd80);
    put(7, SelEnd, $urandom);
    put(7, 5'd31, 32'hFFFF_FFFF);
    put(3, SelCtrl, 32'h0);
    classify(32'h0, 32'h0, 8'h0, 8'd0, 16'h0, 16'h0);

    sent = 0;
    while (sent < NumRandom) begin
      if ($urandom_range(0, 9) < 7) begin
        load_rule(n);
        sent += n;
      end else begin
        w = rand_word();
        if (w.action == ACT_WRITE) put(int'(w.rule_index), w.word_select, w.write_value);
        else random_classify();
        sent++;
      end
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) $display("PASS ipv4_rule_classifier_unit");
    else $display("FAIL ipv4_rule_classifier_unit");
    $finish;
  end

endmodule
